[rtl/sbag_pkg.sv]
// Shared constants, register codes and types of the strided block address generator.
`timescale 1ns / 1ps

package sbag_pkg;

  // Sizing of the position counter.
  localparam int MAX_LEVELS = 3;
  localparam int COUNT_BITS = 16;

  // Fixed field and register widths.
  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 31;
  localparam int CNT_REG_W  = 16;
  localparam int LVL_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_LEVELS = 3;

  // Stride levels that actually keep a digit.
  localparam int LEVELS = (MAX_LEVELS < CFG_LEVELS) ? MAX_LEVELS : CFG_LEVELS;

  // Width used when a digit is compared with a configured count.
  localparam int CMP_W = (COUNT_BITS > CNT_REG_W) ? COUNT_BITS : CNT_REG_W;

  // Width of one digit times one stride.
  localparam int PROD_W = COUNT_BITS + LEN_W;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Stream data widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = ((ADDR_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ADDR_W + LEN_W + 7) / 8) * 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_COUNT   = 3'd0,
    CFG_BLOCK_BYTES   = 3'd1,
    CFG_COUNT_LEVEL1  = 3'd2,
    CFG_COUNT_LEVEL2  = 3'd3,
    CFG_COUNT_LEVEL3  = 3'd4,
    CFG_STRIDE_LEVEL1 = 3'd5,
    CFG_STRIDE_LEVEL2 = 3'd6,
    CFG_STRIDE_LEVEL3 = 3'd7
  } cfg_index_e;

  // Settings the front part needs to run the digit counter.
  typedef struct packed {
    logic [LVL_W-1:0]                      level_count;
    logic [CFG_LEVELS-1:0][CNT_REG_W-1:0] counts;
  } front_cfg_t;

  // Per-level strides used by the back part.
  typedef logic [CFG_LEVELS-1:0][LEN_W-1:0] stride_set_t;

  // One classified item: digits of this block, masked to active levels.
  typedef struct packed {
    logic                                 last;
    logic [LEVELS-1:0][COUNT_BITS-1:0]   digits;
    logic [ADDR_W-1:0]                    base;
  } entry_t;

endpackage

[rtl/sbag_front.sv]
// Front part: accepts items, keeps the position digits and runs the carry chain.
`timescale 1ns / 1ps

module sbag_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sbag_pkg::front_cfg_t      cfg_i,
  input  logic                      in_valid_i,
  input  logic                      in_restart_i,
  input  logic [sbag_pkg::ADDR_W-1:0] in_base_i,
  input  logic                      q_ready_i,
  output logic                      push_o,
  output sbag_pkg::entry_t          entry_o
);

  logic [sbag_pkg::LEVELS-1:0][sbag_pkg::COUNT_BITS-1:0] digit_q, digit_d;
  logic [sbag_pkg::LEVELS-1:0][sbag_pkg::COUNT_BITS-1:0] used;
  logic [sbag_pkg::CNT_REG_W-1:0]                        final_pos;
  logic [sbag_pkg::LVL_W-1:0]                            active;
  logic                                                  carry;

  assign push_o = in_valid_i && q_ready_i;

  // Levels in use, limited to the digits that exist.
  always_comb begin
    if (int'(cfg_i.level_count) > sbag_pkg::LEVELS) begin
      active = sbag_pkg::LVL_W'(sbag_pkg::LEVELS);
    end else begin
      active = cfg_i.level_count;
    end
  end

  // Restart, then the mixed-radix increment with level one as fastest digit.
  always_comb begin
    used      = in_restart_i ? '0 : digit_q;
    digit_d   = used;
    carry     = 1'b1;
    final_pos = '0;
    entry_o.base = in_base_i;
    for (int k = 0; k < sbag_pkg::LEVELS; k++) begin
      entry_o.digits[k] = (k < int'(active)) ? used[k] : '0;
      // A zero count behaves as a count of one.
      final_pos = (cfg_i.counts[k] == '0) ? '0 : cfg_i.counts[k] - 1'b1;
      if ((k < int'(active)) && carry) begin
        if (sbag_pkg::CMP_W'(used[k]) >= sbag_pkg::CMP_W'(final_pos)) begin
          digit_d[k] = '0;
        end else begin
          digit_d[k] = used[k] + 1'b1;
          carry      = 1'b0;
        end
      end
    end
    entry_o.last = carry;
  end

  // Digits move once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else if (push_o) begin
      digit_q <= digit_d;
    end
  end

endmodule

[rtl/sbag_queue.sv]
// Short queue of classified items between the front and the back part.
`timescale 1ns / 1ps

module sbag_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sbag_pkg::entry_t push_entry_i,
  output logic             not_full_o,
  output logic             not_empty_o,
  input  logic             pop_i,
  output sbag_pkg::entry_t pop_entry_o
);

  localparam int PtrW = (sbag_pkg::QUEUE_DEPTH > 1) ? $clog2(sbag_pkg::QUEUE_DEPTH) : 1;
  localparam int FillW = $clog2(sbag_pkg::QUEUE_DEPTH + 1);

  sbag_pkg::entry_t  slot_q [sbag_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0]  fill_q, fill_d;

  assign not_full_o  = (fill_q != FillW'(sbag_pkg::QUEUE_DEPTH));
  assign not_empty_o = (fill_q != '0);
  assign pop_entry_o = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(sbag_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(sbag_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

[rtl/sbag_back.sv]
// Back part: multiplies digits by strides and sums the block address in three stages.
`timescale 1ns / 1ps

module sbag_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sbag_pkg::stride_set_t       strides_i,
  input  logic                        q_valid_i,
  input  sbag_pkg::entry_t            q_entry_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sbag_pkg::ADDR_W-1:0] out_addr_o,
  output logic                        out_last_o
);

  logic advance;

  // Stage one: one product per level.
  logic                                            v1_q;
  logic [sbag_pkg::LEVELS-1:0][sbag_pkg::PROD_W-1:0] prod_q;
  logic [sbag_pkg::ADDR_W-1:0]                     base1_q;
  logic                                            last1_q;

  // Stage two: two partial sums.
  logic                        v2_q;
  logic [sbag_pkg::ADDR_W-1:0] lo_q, hi_d, hi_q;
  logic                        last2_q;

  // Stage three: output register.
  logic                        v3_q;
  logic [sbag_pkg::ADDR_W-1:0] addr_q;
  logic                        last3_q;

  // The whole pipe moves whenever the output slot is free or being taken.
  assign advance     = !v3_q || out_ready_i;
  assign pop_o       = q_valid_i && advance;
  assign out_valid_o = v3_q;
  assign out_addr_o  = addr_q;
  assign out_last_o  = last3_q;

  // Sum of the upper products, all taken modulo the address width.
  always_comb begin
    hi_d = '0;
    for (int k = 1; k < sbag_pkg::LEVELS; k++) begin
      hi_d = hi_d + sbag_pkg::ADDR_W'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int k = 0; k < sbag_pkg::LEVELS; k++) begin
        prod_q[k] <= sbag_pkg::PROD_W'(q_entry_i.digits[k]) *
                     sbag_pkg::PROD_W'(strides_i[k]);
      end
      base1_q <= q_entry_i.base;
      last1_q <= q_entry_i.last;
      lo_q    <= base1_q + sbag_pkg::ADDR_W'(prod_q[0]);
      hi_q    <= hi_d;
      last2_q <= last1_q;
      addr_q  <= lo_q + hi_q;
      last3_q <= last2_q;
    end
  end

endmodule

[rtl/strided_block_address_generator.sv]
// Top level of the strided block address generator: configuration registers and stream ports.
`timescale 1ns / 1ps

// Each accepted item requests the next contiguous block of a strided pattern and yields one
// result item with the block address (base plus each level digit times its stride, modulo
// 2^48), the configured block length, and tlast on the final block of the pattern. Items are
// taken at one per cycle while the two-entry queue has room: the digit counter and its carry
// chain finish in the cycle an item is accepted, and the three stride products and their sum
// run through a three-stage pipeline behind the queue. Set tuser on an item to zero all level
// digits before that block. Write configuration only while no items are in flight.
module strided_block_address_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [sbag_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sbag_pkg::LEN_W-1:0]       cfg_wdata_i,
  // Input stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [sbag_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // base_address
  input  logic                             s_axis_tuser_i,   // restart
  // Output stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [sbag_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,   // block_address, block_length
  output logic                             m_axis_tlast_o    // last_block
);

  logic [sbag_pkg::LVL_W-1:0]                                level_count_q;
  logic [sbag_pkg::LEN_W-1:0]                                block_bytes_q;
  logic [sbag_pkg::CFG_LEVELS-1:0][sbag_pkg::CNT_REG_W-1:0] counts_q;
  sbag_pkg::stride_set_t                                     strides_q;

  sbag_pkg::front_cfg_t        front_cfg;
  sbag_pkg::entry_t            push_entry;
  sbag_pkg::entry_t            pop_entry;
  logic                        push;
  logic                        pop;
  logic                        q_not_full;
  logic                        q_not_empty;
  logic [sbag_pkg::ADDR_W-1:0] out_addr;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= '0;
      block_bytes_q <= sbag_pkg::LEN_W'(1);
      for (int k = 0; k < sbag_pkg::CFG_LEVELS; k++) begin
        counts_q[k]  <= sbag_pkg::CNT_REG_W'(1);
        strides_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (sbag_pkg::cfg_index_e'(cfg_index_i))
        sbag_pkg::CFG_LEVEL_COUNT:   level_count_q <= cfg_wdata_i[sbag_pkg::LVL_W-1:0];
        sbag_pkg::CFG_BLOCK_BYTES:   block_bytes_q <= cfg_wdata_i;
        sbag_pkg::CFG_COUNT_LEVEL1:  counts_q[0]   <= cfg_wdata_i[sbag_pkg::CNT_REG_W-1:0];
        sbag_pkg::CFG_COUNT_LEVEL2:  counts_q[1]   <= cfg_wdata_i[sbag_pkg::CNT_REG_W-1:0];
        sbag_pkg::CFG_COUNT_LEVEL3:  counts_q[2]   <= cfg_wdata_i[sbag_pkg::CNT_REG_W-1:0];
        sbag_pkg::CFG_STRIDE_LEVEL1: strides_q[0]  <= cfg_wdata_i;
        sbag_pkg::CFG_STRIDE_LEVEL2: strides_q[1]  <= cfg_wdata_i;
        sbag_pkg::CFG_STRIDE_LEVEL3: strides_q[2]  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign front_cfg.level_count = level_count_q;
  assign front_cfg.counts      = counts_q;
  assign s_axis_tready_o       = q_not_full;

  sbag_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (front_cfg),
    .in_valid_i   (s_axis_tvalid_i),
    .in_restart_i (s_axis_tuser_i),
    .in_base_i    (s_axis_tdata_i[sbag_pkg::ADDR_W-1:0]),
    .q_ready_i    (q_not_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  sbag_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .not_full_o   (q_not_full),
    .not_empty_o  (q_not_empty),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  sbag_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .strides_i   (strides_q),
    .q_valid_i   (q_not_empty),
    .q_entry_i   (pop_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_addr_o  (out_addr),
    .out_last_o  (m_axis_tlast_o)
  );

  // The user must keep block length static while items are in flight; the block does not enforce it.
  assign m_axis_tdata_o = {
    {(sbag_pkg::OUT_TDATA_W - sbag_pkg::ADDR_W - sbag_pkg::LEN_W){1'b0}},
    block_bytes_q,
    out_addr
  };

endmodule

[rtl/sbag_checker.sv]
// Port-level checks of the strided block address generator, bound to the top level.
`timescale 1ns / 1ps

module sbag_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_we_i,
  input logic [sbag_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [sbag_pkg::LEN_W-1:0]       cfg_wdata_i,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [sbag_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tlast_o
);

  logic                       in_fire;
  logic                       out_fire;
  logic [3:0]                 pending_q;
  logic [sbag_pkg::LEN_W-1:0] block_bytes_q;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  // Items accepted but not yet answered, and a copy of the block length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= '0;
      block_bytes_q <= sbag_pkg::LEN_W'(1);
    end else begin
      if (in_fire && !out_fire) begin
        pending_q <= pending_q + 1'b1;
      end else if (out_fire && !in_fire) begin
        pending_q <= pending_q - 1'b1;
      end
      if (cfg_we_i && (cfg_index_i == sbag_pkg::CFG_BLOCK_BYTES)) begin
        block_bytes_q <= cfg_wdata_i;
      end
    end
  end

  // A result waiting for the sink stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // No result appears without an accepted item behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pending_q != '0)
    else $error("result without a pending item");

  // The length field follows the block length register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[sbag_pkg::ADDR_W +: sbag_pkg::LEN_W] == block_bytes_q)
    else $error("block length does not match configuration");

endmodule

bind strided_block_address_generator sbag_checker u_sbag_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .cfg_index_i     (cfg_index_i),
  .cfg_wdata_i     (cfg_wdata_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

[tb/strided_block_address_generator_test.sv]
// Self-checking testbench for the strided block address generator stream block.
`timescale 1ns / 1ps

module strided_block_address_generator_test;

  localparam int CYCLE_LIMIT = 300000;

  // One block request sent on the input stream.
  typedef struct packed {
    logic                        restart;
    logic [sbag_pkg::ADDR_W-1:0] base;
  } block_req_t;

  // One block descriptor as the block should return it.
  typedef struct packed {
    logic [sbag_pkg::ADDR_W-1:0] addr;
    logic [sbag_pkg::LEN_W-1:0]  len;
    logic                        last;
  } block_desc_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             cfg_we_i = 1'b0;
  logic [sbag_pkg::CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [sbag_pkg::LEN_W-1:0]       cfg_wdata_i = '0;

  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [sbag_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i = '0;   // base_address
  logic                             s_axis_tuser_i = 1'b0; // restart

  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [sbag_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;        // block_address, block_length
  logic                             m_axis_tlast_o;        // last_block

  strided_block_address_generator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Walk settings as last written, and the position digits of the walk.
  logic [sbag_pkg::LVL_W-1:0]      walk_levels = '0;
  logic [sbag_pkg::LEN_W-1:0]      walk_block_bytes = 31'd1;
  logic [sbag_pkg::CNT_REG_W-1:0]  walk_counts [sbag_pkg::CFG_LEVELS] = '{default: 16'd1};
  logic [sbag_pkg::LEN_W-1:0]      walk_strides [sbag_pkg::CFG_LEVELS] = '{default: '0};
  logic [sbag_pkg::COUNT_BITS-1:0] walk_digits [sbag_pkg::LEVELS] = '{default: '0};

  block_req_t  block_requests [$];
  block_desc_t predicted_descs [$];
  block_req_t  next_req;

  int  cycles = 0;
  int  mismatches = 0;
  int  blocks_checked = 0;
  int  last_blocks_seen = 0;
  int  phases_run = 0;
  int  send_gap = 0;
  int  sink_stall = 0;
  bit  steady = 1'b0;

  always #4 clk_i = ~clk_i;

  // Run-away guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               predicted_descs.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Computes the descriptor of the next block and advances the digit counter.
  function automatic block_desc_t next_block_desc(input logic restart,
                                                  input logic [sbag_pkg::ADDR_W-1:0] base);
    block_desc_t                    desc;
    logic [63:0]                    acc;
    logic [sbag_pkg::CNT_REG_W-1:0] top_digit;
    int                             active;
    bit                             carry;
    active = (int'(walk_levels) > sbag_pkg::LEVELS) ? sbag_pkg::LEVELS : int'(walk_levels);
    if (restart) begin
      for (int k = 0; k < sbag_pkg::LEVELS; k++) walk_digits[k] = '0;
    end
    acc = 64'(base);
    for (int k = 0; k < active; k++) acc += 64'(walk_digits[k]) * 64'(walk_strides[k]);
    // Mixed-radix increment: a digit at or past its top value wraps and carries on.
    carry = 1'b1;
    for (int k = 0; k < active; k++) begin
      if (carry) begin
        top_digit = (walk_counts[k] == 0) ? '0 : walk_counts[k] - 1'b1;
        if (sbag_pkg::CMP_W'(walk_digits[k]) >= sbag_pkg::CMP_W'(top_digit)) begin
          walk_digits[k] = '0;
        end else begin
          walk_digits[k] = walk_digits[k] + 1'b1;
          carry = 1'b0;
        end
      end
    end
    desc.addr = acc[sbag_pkg::ADDR_W-1:0];
    desc.len  = walk_block_bytes;
    desc.last = carry;
    return desc;
  endfunction

  // Sender: presents queued block requests, with random gaps between items.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= 1'b0;
      send_gap        <= 0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (send_gap != 0) begin
        send_gap        <= send_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (block_requests.size() != 0) begin
        next_req = block_requests.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= next_req.base;
        s_axis_tuser_i  <= next_req.restart;
        if (!steady && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 9);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: ready most of the time, with random stall bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_stall      <= 0;
    end else if (sink_stall != 0) begin
      sink_stall      <= sink_stall - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!steady && $urandom_range(0, 6) == 0) begin
      sink_stall      <= $urandom_range(0, 8);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Checker: compares each result item with the oldest prediction, then predicts
  // the result of any item accepted at this edge.
  always @(posedge clk_i) begin
    block_desc_t want;
    block_desc_t got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.addr = m_axis_tdata_o[sbag_pkg::ADDR_W-1:0];
        got.len  = m_axis_tdata_o[sbag_pkg::ADDR_W +: sbag_pkg::LEN_W];
        got.last = m_axis_tlast_o;
        blocks_checked++;
        if (got.last) last_blocks_seen++;
        if (predicted_descs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none expected: addr %h len %h last %b",
                     $realtime, got.addr, got.len, got.last);
        end else begin
          want = predicted_descs.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected addr %h len %h last %b, got addr %h len %h last %b",
                       $realtime, want.addr, want.len, want.last,
                       got.addr, got.len, got.last);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        predicted_descs.push_back(next_block_desc(s_axis_tuser_i,
                                                  s_axis_tdata_i[sbag_pkg::ADDR_W-1:0]));
    end
  end

  // Writes one configuration register.
  task automatic write_reg(input sbag_pkg::cfg_index_e idx,
                           input logic [sbag_pkg::LEN_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Programs the whole walk and mirrors it in the predictor.
  task automatic program_walk(input logic [sbag_pkg::LVL_W-1:0] levels,
                              input logic [sbag_pkg::LEN_W-1:0] bytes,
                              input logic [sbag_pkg::CNT_REG_W-1:0] c1, c2, c3,
                              input logic [sbag_pkg::LEN_W-1:0] s1, s2, s3);
    write_reg(sbag_pkg::CFG_LEVEL_COUNT, sbag_pkg::LEN_W'(levels));
    write_reg(sbag_pkg::CFG_BLOCK_BYTES, bytes);
    write_reg(sbag_pkg::CFG_COUNT_LEVEL1, sbag_pkg::LEN_W'(c1));
    write_reg(sbag_pkg::CFG_COUNT_LEVEL2, sbag_pkg::LEN_W'(c2));
    write_reg(sbag_pkg::CFG_COUNT_LEVEL3, sbag_pkg::LEN_W'(c3));
    write_reg(sbag_pkg::CFG_STRIDE_LEVEL1, s1);
    write_reg(sbag_pkg::CFG_STRIDE_LEVEL2, s2);
    write_reg(sbag_pkg::CFG_STRIDE_LEVEL3, s3);
    walk_levels      = levels;
    walk_block_bytes = bytes;
    walk_counts      = '{c1, c2, c3};
    walk_strides     = '{s1, s2, s3};
    phases_run++;
  endtask

  // Waits until every queued item has been sent and every result has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (block_requests.size() != 0 || s_axis_tvalid_i || predicted_descs.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic send(input logic restart, input logic [sbag_pkg::ADDR_W-1:0] base);
    block_requests.push_back('{restart: restart, base: base});
  endtask

  function automatic logic [sbag_pkg::ADDR_W-1:0] rand_addr();
    return sbag_pkg::ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [sbag_pkg::LEN_W-1:0] rand_stride();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return {sbag_pkg::LEN_W{1'b1}};
      2: return sbag_pkg::LEN_W'($urandom_range(1, 4096));
      default: return sbag_pkg::LEN_W'($urandom);
    endcase
  endfunction

  function automatic logic [sbag_pkg::CNT_REG_W-1:0] rand_count();
    if ($urandom_range(0, 9) != 0) return sbag_pkg::CNT_REG_W'($urandom_range(1, 5));
    case ($urandom_range(0, 2))
      0: return '0;
      1: return {sbag_pkg::CNT_REG_W{1'b1}};
      default: return sbag_pkg::CNT_REG_W'($urandom);
    endcase
  endfunction

  function automatic logic [sbag_pkg::LEN_W-1:0] rand_bytes();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return sbag_pkg::LEN_W'(1);
      2: return {sbag_pkg::LEN_W{1'b1}};
      default: return sbag_pkg::LEN_W'($urandom);
    endcase
  endfunction

  // Queues one random phase: mostly a steady walk over one region, some noise.
  task automatic queue_random_walk(input int n_items);
    logic [sbag_pkg::ADDR_W-1:0] region;
    region = rand_addr();
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) == 0)
        send(1'($urandom_range(0, 1)), rand_addr());
      else
        send((i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0), region);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: no levels, so every block sits at its base and is a last block.
    send(1'b0, '0);
    send(1'b0, {sbag_pkg::ADDR_W{1'b1}});
    send(1'b1, 48'h5555_5555_5555);
    wait_drained();

    // Three full levels at the largest strides and length; the sum wraps past 2^48.
    program_walk(2'd3, {sbag_pkg::LEN_W{1'b1}}, 16'd2, 16'd2, 16'd2,
                 {sbag_pkg::LEN_W{1'b1}}, {sbag_pkg::LEN_W{1'b1}}, {sbag_pkg::LEN_W{1'b1}});
    for (int i = 0; i < 9; i++) send(1'b0, 48'hFFFF_FFFF_FF00);
    wait_drained();

    // A zero count keeps its digit final; a zero length is passed through.
    program_walk(2'd2, '0, 16'd0, 16'd3, 16'd1, 31'd16, 31'd4096, '0);
    for (int i = 0; i < 4; i++) send(1'b0, 48'h0000_1000_0000);
    wait_drained();

    // Leave level one at digit four, then shrink its count so the digit is past the end.
    program_walk(2'd1, 31'd64, 16'd6, 16'd1, 16'd1, 31'd8, 31'd100, 31'd200);
    for (int i = 0; i < 4; i++) send(i == 0, 48'h0000_0000_0100);
    wait_drained();
    program_walk(2'd1, 31'd64, 16'd3, 16'd1, 16'd1, 31'd8, 31'd100, 31'd200);
    send(1'b0, 48'h0000_0000_0100);
    send(1'b0, 48'h0000_0000_0100);
    send(1'b0, 48'h0000_0000_0100);
    wait_drained();

    // An inactive level keeps its digit until the level comes back; restart clears it.
    program_walk(2'd0, 31'd64, 16'd3, 16'd1, 16'd1, 31'd8, 31'd100, 31'd200);
    send(1'b0, 48'h0000_0000_0100);
    wait_drained();
    program_walk(2'd1, 31'd64, 16'd3, 16'd1, 16'd1, 31'd8, 31'd100, 31'd200);
    send(1'b0, 48'h0000_0000_0100);
    send(1'b1, 48'h0000_0000_0100);
    wait_drained();

    // Random phases; settings change without restart so stale digits carry over.
    for (int ph = 0; ph < 13; ph++) begin
      if (ph == 10) steady = 1'b1;
      program_walk(sbag_pkg::LVL_W'($urandom_range(0, 3)), rand_bytes(), rand_count(),
                   rand_count(), rand_count(), rand_stride(), rand_stride(), rand_stride());
      if (ph == 4) begin
        // The sender holds off mid-phase until every result is back.
        queue_random_walk(35);
        wait_drained();
        queue_random_walk(35);
      end else begin
        queue_random_walk(70);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("Walked %0d blocks over %0d register settings, %0d of them pattern ends.",
             blocks_checked, phases_run, last_blocks_seen);
    $display("Mismatches: %0d, results still due: %0d.", mismatches, predicted_descs.size());
    if (mismatches == 0 && predicted_descs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
